// ===== design/u8to16_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 to UTF-16BE stream transcoder.
`default_nettype none

package u8to16_pkg;

    // Longest source string the length counter is sized for.
    localparam int MAX_IN_BYTES = 65536;

    // Output length counter saturates here.
    localparam logic [17:0] CNT_LIMIT =
        ((2 * MAX_IN_BYTES) > 'h3FFFF) ? 18'h3FFFF : 18'(2 * MAX_IN_BYTES);

    // Job queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // Code point limits and surrogate bases.
    localparam logic [20:0] CP_MAX   = 21'h10FFFF;
    localparam logic [20:0] CP_SUPP  = 21'h010000;
    localparam logic [20:0] CH_QMARK = 21'h00003F;
    localparam logic [15:0] SURR_HI  = 16'hD800;
    localparam logic [15:0] SURR_LO  = 16'hDC00;
    localparam logic [9:0]  SURR_MSK = 10'h3FF;

    // Lead byte boundaries.
    localparam logic [7:0] LEAD_TWO_MIN   = 8'h80;
    localparam logic [7:0] LEAD_THREE_MIN = 8'hE0;
    localparam logic [7:0] LEAD_FOUR_MIN  = 8'hF0;
    localparam logic [7:0] LEAD_BAD_MIN   = 8'hF8;

    // Results per job: up to four code bytes and two terminator bytes.
    localparam logic [2:0] N_BMP  = 3'd2;
    localparam logic [2:0] N_PAIR = 3'd4;
    localparam logic [2:0] N_TERM = 3'd2;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_BAD
    } t_lead;

    // One unit of work for the back end: zero, one or two UTF-16 words,
    // optionally followed by the terminator.
    typedef struct packed {
        logic        have;
        logic        is_pair;
        logic [15:0] w0;
        logic [15:0] w1;
        logic        last;
    } t_job;

    function automatic t_lead classify(input logic [7:0] b);
        t_lead k;
        priority if (b < LEAD_TWO_MIN)   k = LEAD_ASCII;
        else if     (b < LEAD_THREE_MIN) k = LEAD_TWO;
        else if     (b < LEAD_FOUR_MIN)  k = LEAD_THREE;
        else if     (b < LEAD_BAD_MIN)   k = LEAD_FOUR;
        else                             k = LEAD_BAD;
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== design/u8to16_front.sv =====
// Front end: accepts UTF-8 bytes, gathers code points and posts UTF-16 jobs.
`default_nettype none

module u8to16_front
    import u8to16_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_job            o_job
);

    logic [20:0] r_acc;
    logic [1:0]  r_left;
    logic [20:0] n_acc;
    logic [1:0]  n_left;
    logic        have;
    logic [20:0] cp;
    logic [20:0] cp_ok;
    logic [20:0] cp_off;
    logic        accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_acc  = r_acc;
        n_left = r_left;
        have   = 1'b0;
        cp     = '0;
        if (r_left == 2'd0) begin
            unique case (classify(i_byte))
                LEAD_ASCII: begin
                    cp   = {13'b0, i_byte};
                    have = 1'b1;
                end
                LEAD_TWO: begin
                    n_acc  = {16'b0, i_byte[4:0]};
                    n_left = 2'd1;
                end
                LEAD_THREE: begin
                    n_acc  = {17'b0, i_byte[3:0]};
                    n_left = 2'd2;
                end
                LEAD_FOUR: begin
                    n_acc  = {18'b0, i_byte[2:0]};
                    n_left = 2'd3;
                end
                default: begin
                    cp   = CH_QMARK;
                    have = 1'b1;
                end
            endcase
        end else begin
            n_acc  = {r_acc[14:0], i_byte[5:0]};
            n_left = r_left - 2'd1;
            if (n_left == 2'd0) begin
                cp   = n_acc;
                have = 1'b1;
            end
        end
        // truncated sequence at end of string: missing bytes read as zero
        if (i_last && n_left != 2'd0) begin
            have = 1'b1;
            unique case (n_left)
                2'd1:    cp = {n_acc[14:0], 6'b0};
                2'd2:    cp = {n_acc[8:0], 12'b0};
                2'd3:    cp = {n_acc[2:0], 18'b0};
                default: cp = n_acc;
            endcase
        end
    end

    always_comb begin
        cp_ok  = (cp > CP_MAX) ? CH_QMARK : cp;
        cp_off = cp_ok - CP_SUPP;
        o_job.have    = have;
        o_job.is_pair = (cp_ok >= CP_SUPP);
        o_job.w0      = o_job.is_pair ? (SURR_HI + {6'b0, cp_off[19:10]}) : cp_ok[15:0];
        o_job.w1      = SURR_LO | {6'b0, cp_ok[9:0] & SURR_MSK};
        o_job.last    = i_last;
        o_push        = accept && (have || i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_left <= '0;
        end else if (accept) begin
            if (i_last) begin
                r_acc  <= '0;
                r_left <= '0;
            end else begin
                r_acc  <= n_acc;
                r_left <= n_left;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/u8to16_queue.sv =====
// Short job queue decoupling the front end from the back end.
`default_nettype none

module u8to16_queue
    import u8to16_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    output logic      o_valid,
    input  wire logic i_pop,
    output t_job      o_job
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue underflow");
`endif

endmodule

`default_nettype wire

// ===== design/u8to16_back.sv =====
// Back end: serialises jobs into UTF-16BE bytes and tracks the output length.
`default_nettype none

module u8to16_back
    import u8to16_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_job_valid,
    input  wire t_job        i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_byte,
    output logic             o_run_end,
    output logic             o_term,
    output logic [17:0]      o_len
);

    logic [2:0]  r_idx;
    logic [17:0] r_cnt;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_run_end;
    logic        r_term;
    logic [17:0] r_len;

    logic [2:0]  n_code;
    logic [2:0]  n_total;
    logic        load;
    logic        is_term;
    logic        is_end;
    logic [7:0]  cur_byte;
    logic [17:0] n_cnt;

    always_comb begin
        n_code  = i_job.have ? (i_job.is_pair ? N_PAIR : N_BMP) : 3'd0;
        n_total = n_code + (i_job.last ? N_TERM : 3'd0);
        is_term = (r_idx >= n_code);
        is_end  = (r_idx == n_total - 3'd1);
        unique case (r_idx[1:0])
            2'd0:    cur_byte = i_job.w0[15:8];
            2'd1:    cur_byte = i_job.w0[7:0];
            2'd2:    cur_byte = i_job.w1[15:8];
            default: cur_byte = i_job.w1[7:0];
        endcase
        if (is_term) begin
            cur_byte = 8'h00;
        end
        n_cnt = (!is_term && r_cnt < CNT_LIMIT) ? r_cnt + 18'd1 : r_cnt;
        load  = i_job_valid && (!r_valid || i_ready);
        o_pop = load && is_end;
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte    <= cur_byte;
            r_run_end <= is_end;
            r_term    <= is_term;
            r_len     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                r_idx <= is_end ? 3'd0 : r_idx + 3'd1;
                // second terminator byte closes the string
                r_cnt <= (is_end && is_term) ? 18'd0 : n_cnt;
            end
        end
    end

    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_run_end = r_run_end;
    assign o_term    = r_term;
    assign o_len     = r_len;

`ifndef SYNTH
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_LIMIT)
        else $error("length counter beyond limit");
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_term) |-> (r_byte == 8'h00))
        else $error("terminator byte not zero");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> (r_idx < n_total))
        else $error("byte index past job end");
`endif

endmodule

`default_nettype wire

// ===== design/utf8_to_utf16be_stream.sv =====
// Top level of the UTF-8 to UTF-16BE stream transcoder.
//
// Input stream s_axis: one UTF-8 byte per item in tdata, tlast on the final
// byte of a string. Output stream m_axis: one UTF-16BE byte per item;
// tdata[7:0] is the byte, tdata[25:8] the running output length of the string
// (terminator excluded, saturating), tuser flags the two trailing zero bytes,
// tlast marks the last output item caused by a given input byte.
// Lead bytes are classified in the front end, which posts at most one job per
// input item into a four-entry queue; the back end turns each job into 0, 2 or
// 4 code bytes plus 2 terminator bytes on the final input, one per cycle
// while the receiver is ready. An accepted input byte's job is written into
// the queue, and from there its first byte goes to the back end's output
// register. The back end's single output byte per cycle sets the pace; an
// input byte causes 0 to 6 output items. The front end takes a byte every
// cycle while the queue has room, so bytes inside a multi-byte sequence
// overlap with output of earlier characters.
// Reset (synchronous, active low) clears the decoder, queue, length counter
// and output valid. A stalled receiver holds the output register; the queue
// then fills and s_axis_tready drops until space frees up.
`default_nettype none

module utf8_to_utf16be_stream
    import u8to16_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [25:8] total_length, zero pad
    output logic             m_axis_tlast,   // run_end
    output logic             m_axis_tuser    // is_terminator
);

    logic  q_full;
    logic  push;
    t_job  job_in;
    logic  q_valid;
    logic  pop;
    t_job  job_out;
    logic [7:0]  out_byte;
    logic [17:0] out_len;

    u8to16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job_in)
    );

    u8to16_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_job   (job_out)
    );

    u8to16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (job_out),
        .o_pop       (pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_byte      (out_byte),
        .o_run_end   (m_axis_tlast),
        .o_term      (m_axis_tuser),
        .o_len       (out_len)
    );

    assign m_axis_tdata = {6'b0, out_len, out_byte};

endmodule

`default_nettype wire

// ===== dv/utf16_stream_checker.sv =====
// Stream checker for the UTF-8 to UTF-16BE transcoder: predicts output items and compares them.
module utf16_stream_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] data_byte
    input  logic        i_in_last,    // last_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // [7:0] out_byte, [25:8] total_length, zero pad
    input  logic        i_out_last,   // run_end
    input  logic        i_out_user,   // is_terminator
    output int          o_mismatches,
    output int          o_pending
);

    localparam int LEN_LIMIT_I = (2 * u8to16_pkg::MAX_IN_BYTES > 'h3FFFF) ?
                                 'h3FFFF : 2 * u8to16_pkg::MAX_IN_BYTES;
    localparam logic [17:0] LEN_LIMIT = 18'(LEN_LIMIT_I);

    localparam logic [7:0]  TWO_MIN   = 8'h80;
    localparam logic [7:0]  THREE_MIN = 8'hE0;
    localparam logic [7:0]  FOUR_MIN  = 8'hF0;
    localparam logic [7:0]  BAD_MIN   = 8'hF8;
    localparam logic [20:0] CP_TOP    = 21'h10FFFF;
    localparam logic [20:0] SUPP_BASE = 21'h010000;
    localparam logic [20:0] QMARK     = 21'h00003F;
    localparam logic [15:0] HI_BASE   = 16'hD800;
    localparam logic [15:0] LO_BASE   = 16'hDC00;

    typedef struct packed {
        logic [7:0]  ch_byte;
        logic        run_end;
        logic        term;
        logic [17:0] length;
    } t_utf16_item;

    t_utf16_item utf16_exp_q[$];
    t_utf16_item step_items[0:5];
    int          step_n;
    int          mismatches = 0;

    // decoder state
    logic [20:0] code_bits;
    logic [1:0]  cont_left;
    logic [17:0] len_count;

    task automatic put_out_byte(input logic [7:0] v, input logic term);
        if (!term && len_count < LEN_LIMIT)
            len_count = len_count + 18'd1;
        step_items[step_n] = {v, 1'b0, term, len_count};
        step_n = step_n + 1;
    endtask

    task automatic put_code_point(input logic [20:0] cp);
        logic [20:0] off;
        logic [15:0] hi;
        logic [15:0] lo;
        if (cp > CP_TOP)
            cp = QMARK;
        if (cp < SUPP_BASE) begin
            put_out_byte(cp[15:8], 1'b0);
            put_out_byte(cp[7:0], 1'b0);
        end else begin
            off = cp - SUPP_BASE;
            hi  = HI_BASE + {6'd0, off[19:10]};
            lo  = LO_BASE + {6'd0, off[9:0]};
            put_out_byte(hi[15:8], 1'b0);
            put_out_byte(hi[7:0], 1'b0);
            put_out_byte(lo[15:8], 1'b0);
            put_out_byte(lo[7:0], 1'b0);
        end
    endtask

    task automatic transcode_byte(input logic [7:0] b, input logic last);
        logic        have;
        logic [20:0] cp;
        have   = 1'b0;
        cp     = '0;
        step_n = 0;
        if (cont_left == 2'd0) begin
            if (b < TWO_MIN) begin
                cp   = {13'd0, b};
                have = 1'b1;
            end else if (b < THREE_MIN) begin
                code_bits = {16'd0, b[4:0]};
                cont_left = 2'd1;
            end else if (b < FOUR_MIN) begin
                code_bits = {17'd0, b[3:0]};
                cont_left = 2'd2;
            end else if (b < BAD_MIN) begin
                code_bits = {18'd0, b[2:0]};
                cont_left = 2'd3;
            end else begin
                cp   = QMARK;
                have = 1'b1;
            end
        end else begin
            // continuation bits are taken blindly
            code_bits = {code_bits[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) begin
                cp   = code_bits;
                have = 1'b1;
            end
        end
        // truncated tail: missing continuation bytes count as zero
        if (last && cont_left != 2'd0) begin
            while (cont_left != 2'd0) begin
                code_bits = {code_bits[14:0], 6'd0};
                cont_left = cont_left - 2'd1;
            end
            cp   = code_bits;
            have = 1'b1;
        end
        if (have)
            put_code_point(cp);
        if (last) begin
            put_out_byte(8'h00, 1'b1);
            put_out_byte(8'h00, 1'b1);
            code_bits = '0;
            cont_left = '0;
            len_count = '0;
        end
        if (step_n > 0)
            step_items[step_n - 1].run_end = 1'b1;
        for (int i = 0; i < step_n; i++)
            utf16_exp_q.push_back(step_items[i]);
    endtask

    task automatic check_out_item();
        t_utf16_item got;
        t_utf16_item want;
        got = {i_out_data[7:0], i_out_last, i_out_user, i_out_data[25:8]};
        if (utf16_exp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] unexpected output item: byte %02h run_end %0b term %0b len %0d",
                         $time, got.ch_byte, got.run_end, got.term, got.length);
        end else begin
            want = utf16_exp_q.pop_front();
            if (got.ch_byte !== want.ch_byte || got.run_end !== want.run_end ||
                got.term !== want.term || got.length !== want.length) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("[%0t] output mismatch (exp/act): byte %02h/%02h run_end %0b/%0b ",
                           $time, want.ch_byte, got.ch_byte, want.run_end, got.run_end);
                    $display("term %0b/%0b len %0d/%0d",
                             want.term, got.term, want.length, got.length);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            utf16_exp_q.delete();
            code_bits = '0;
            cont_left = '0;
            len_count = '0;
        end else begin
            if (i_in_valid && i_in_ready)
                transcode_byte(i_in_data, i_in_last);
            if (i_out_valid && i_out_ready)
                check_out_item();
        end
        o_pending    <= utf16_exp_q.size();
        o_mismatches <= mismatches;
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the UTF-8 to UTF-16BE transcoder: stimulus, flow control and verdict.
module tb;
    import u8to16_pkg::*;

    localparam int GAP_MAX        = 14;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS   = 380;
    // one longer string sent flat out near the end, before a short final string
    localparam int LONG_STR_LEN   = 40;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // [7:0] data_byte
    logic        s_axis_tlast;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [7:0] out_byte, [25:8] total_length, zero pad
    logic        m_axis_tlast;    // run_end
    logic        m_axis_tuser;    // is_terminator

    int mismatches;
    int pending;

    // flow-control knobs shared between the sender and receiver processes
    int tx_gap_pct   = 0;
    int rx_stall_pct = 0;
    bit rx_hold_req  = 1'b0;
    int tx_items     = 0;

    // source bytes of the string being built
    logic [7:0] utf8_src_q[$];

    utf8_to_utf16be_stream uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    utf16_stream_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs.
    initial begin
        #(20 * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: ready changes on the falling edge. A requested hold-off keeps
    // ready low for a fixed count so the job queue fills and the input stalls;
    // otherwise short random stall bursts, or none when the stall rate is zero.
    initial begin
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < rx_stall_pct) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, GAP_MAX)) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    // Offers one item on the falling edge, maybe after a random gap, and
    // returns on the rising edge at which it is taken. Valid stays high
    // between back-to-back items.
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < tx_gap_pct) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, GAP_MAX)) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        tx_items++;
    endtask

    // Sender goes quiet until the checker has seen every predicted item.
    task automatic wait_all_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic send_src_string();
        int n;
        n = utf8_src_q.size();
        for (int i = 0; i < n; i++)
            send_byte(utf8_src_q[i], i == n - 1);
        utf8_src_q.delete();
    endtask

    // Appends one well-formed UTF-8 character of the given length class, or one invalid lead byte for LEAD_BAD.
    task automatic push_char(input t_lead kind);
        logic [20:0] cp;
        logic [7:0]  b;
        case (kind)
            LEAD_ASCII: begin
                cp = 21'($urandom_range(0, 'h7F));
                utf8_src_q.push_back(cp[7:0]);
            end
            LEAD_TWO: begin
                cp = 21'($urandom_range('h80, 'h7FF));
                utf8_src_q.push_back({3'b110, cp[10:6]});
                utf8_src_q.push_back({2'b10, cp[5:0]});
            end
            LEAD_THREE: begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                utf8_src_q.push_back({4'b1110, cp[15:12]});
                utf8_src_q.push_back({2'b10, cp[11:6]});
                utf8_src_q.push_back({2'b10, cp[5:0]});
            end
            LEAD_FOUR: begin
                cp = 21'($urandom_range('h10000, 'h10FFFF));
                utf8_src_q.push_back({5'b11110, cp[20:18]});
                utf8_src_q.push_back({2'b10, cp[17:12]});
                utf8_src_q.push_back({2'b10, cp[11:6]});
                utf8_src_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                b = 8'($urandom_range('hF8, 'hFF));
                utf8_src_q.push_back(b);
            end
        endcase
    endtask

    // Mostly well-formed text; noise_pct of the characters are raw random
    // bytes, and cut_tail chops the last character short.
    task automatic build_random_string(input int n_chars, input int noise_pct,
                                       input bit cut_tail);
        int         first;
        int         clen;
        logic [7:0] rnd;
        first = 0;
        for (int i = 0; i < n_chars; i++) begin
            first = utf8_src_q.size();
            if ($urandom_range(0, 99) < noise_pct) begin
                rnd = 8'($urandom_range(0, 255));
                utf8_src_q.push_back(rnd);
            end else begin
                push_char(t_lead'($urandom_range(0, 3)));
            end
        end
        clen = utf8_src_q.size() - first;
        if (cut_tail && clen > 1)
            repeat ($urandom_range(1, clen - 1))
                void'(utf8_src_q.pop_back());
    endtask

    function automatic int pick_rate();
        int r;
        r = $urandom_range(0, 2);
        return (r == 0) ? 0 : (r == 1) ? 15 : 40;
    endfunction

    initial begin
        int         rand_stop;
        int         str_idx;
        logic [7:0] fill;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // --- directed strings, no idling ---
        send_byte(8'h41, 1'b1);                 // single ASCII string
        send_byte(8'h00, 1'b0);                 // field extremes
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b0);                 // invalid leads give '?'
        send_byte(8'hF8, 1'b0);
        send_byte(8'hC3, 1'b0);                 // two-byte form
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);                 // three-byte form
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);                 // four-byte, surrogate pair
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);                 // beyond 0x10FFFF -> '?'
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);                 // stray continuation as lead
        send_byte(8'h3F, 1'b0);
        send_byte(8'hE2, 1'b1);                 // truncated three-byte tail
        send_byte(8'hF7, 1'b0);                 // truncated four-byte, out of range
        send_byte(8'hBF, 1'b1);
        send_byte(8'hC2, 1'b1);                 // lone two-byte lead as whole string
        send_byte(8'h00, 1'b1);
        wait_all_results();

        // --- random strings with random idling on both sides ---
        rand_stop = tx_items + RANDOM_ITEMS;
        str_idx   = 0;
        while (tx_items < rand_stop) begin
            tx_gap_pct   = pick_rate();
            rx_stall_pct = pick_rate();
            if (str_idx == 6) begin
                // receiver holds off while a long string keeps coming
                tx_gap_pct  = 0;
                rx_hold_req = 1'b1;
                build_random_string(30, 0, 1'b0);
            end else begin
                build_random_string($urandom_range(1, 12),
                                    ($urandom_range(0, 9) < 7) ? 0 : 30,
                                    $urandom_range(0, 99) < 15);
            end
            send_src_string();
            str_idx++;
            if (str_idx == 15)
                wait_all_results();
        end

        // --- last part, no idling ---
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        for (int i = 0; i < LONG_STR_LEN; i++) begin
            // ASCII or invalid lead: two output bytes per item either way
            fill = $urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F))
                                        : 8'($urandom_range('hF8, 'hFF));
            send_byte(fill, i == LONG_STR_LEN - 1);
        end
        // short string after it: count must restart from zero
        build_random_string(3, 0, 1'b0);
        send_src_string();

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        for (int k = 0; k < DRAIN_LIMIT && pending != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
